// ===== src/espl_pkg.sv =====
// Package: shared types, constants and command/status structs for the speed loop.
`timescale 1ns / 1ps
package espl_pkg;

    localparam int unsigned CounterBitsDefault = 16;
    localparam int unsigned SpeedNum = 60318592;
    localparam int unsigned SpeedDen = 2500;
    localparam int signed IntegLimit = 12800;
    localparam int unsigned RpmMax = 800;

    typedef enum logic [2:0] {
        CFG_TARGET = 3'd0,
        CFG_GAIN_P = 3'd1,
        CFG_GAIN_I = 3'd2,
        CFG_GAIN_D = 3'd3,
        CFG_WEIGHT = 3'd4,
        CFG_REVERSE = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_MUL,
        ST_DIV,
        ST_FILT,
        ST_ERR,
        ST_INC,
        ST_INTEG,
        ST_PID,
        ST_FREQ,
        ST_PERIOD,
        ST_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic do_delta;
        logic do_mul;
        logic div_start;
        logic do_filt;
        logic do_err;
        logic do_inc;
        logic do_integ;
        logic do_pid;
        logic do_freq;
        logic out_load;
        logic out_idle;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic enable;
        logic zero_ticks;
        logic div_busy;
    } t_sts;

endpackage

// ===== src/espl_divider.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module espl_divider #(
    parameter int unsigned W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_busy,
    output logic [W-1:0] o_quot
);
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_quot, r_den;
    logic [W:0]    r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W:0]    n_shift;

    assign n_shift = {r_rem[W-1:0], r_quot[W-1]};
    assign o_busy  = r_busy;
    assign o_quot  = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W);
            r_quot <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
        end else if (r_busy) begin
            if (n_shift >= {1'b0, r_den}) begin
                r_rem  <= n_shift - {1'b0, r_den};
                r_quot <= {r_quot[W-2:0], 1'b1};
            end else begin
                r_rem  <= n_shift;
                r_quot <= {r_quot[W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule

// ===== src/espl_ctrl.sv =====
// Controller: sequences one control tick through the datapath.
`timescale 1ns / 1ps
module espl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  espl_pkg::t_sts   i_sts,
    output espl_pkg::t_cmd   o_cmd,
    output espl_pkg::t_state o_state
);
    import espl_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_state     = r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DELTA;
                end
            end
            ST_DELTA: begin
                if (!i_sts.enable) begin
                    o_cmd.clear = 1'b1;
                    n_state     = ST_OUT;
                end else begin
                    o_cmd.do_delta = 1'b1;
                    n_state        = i_sts.zero_ticks ? ST_ERR : ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.do_mul    = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = ST_FILT;
                end
            end
            ST_FILT: begin
                o_cmd.do_filt = 1'b1;
                n_state       = ST_ERR;
            end
            ST_ERR: begin
                o_cmd.do_err = 1'b1;
                n_state      = ST_INC;
            end
            ST_INC: begin
                o_cmd.do_inc = 1'b1;
                n_state      = ST_INTEG;
            end
            ST_INTEG: begin
                o_cmd.do_integ = 1'b1;
                n_state        = ST_PID;
            end
            ST_PID: begin
                o_cmd.do_pid = 1'b1;
                n_state      = ST_FREQ;
            end
            ST_FREQ: begin
                o_cmd.do_freq   = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = ST_PERIOD;
            end
            ST_PERIOD: begin
                if (!i_sts.div_busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // Wait for the output register to drain, then load and present the result
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = i_sts.enable;
                    o_cmd.out_idle = !i_sts.enable;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== src/espl_datapath.sv =====
// Datapath: speed measurement, filter, PID and pulse period computation.
`timescale 1ns / 1ps
module espl_datapath #(
    parameter int unsigned COUNTER_BITS = espl_pkg::CounterBitsDefault
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  espl_pkg::t_cmd          i_cmd,
    output espl_pkg::t_sts          o_sts,
    input  logic                    i_loop_enable,
    input  logic [15:0]             i_encoder_count,
    input  logic [31:0]             i_tick_stamp,
    input  logic [17:0]             i_target_speed,
    input  logic [15:0]             i_gain_p,
    input  logic [15:0]             i_gain_i,
    input  logic [15:0]             i_gain_d,
    input  logic [8:0]              i_smoothing_weight,
    input  logic                    i_reverse_direction,
    output logic                    o_drive_valid,
    output logic [9:0]              o_drive_rpm,
    output logic [29:0]             o_pulse_period_ns,
    output logic [28:0]             o_pulse_high_ns,
    output logic                    o_drive_channel,
    output logic signed [31:0]      o_speed_now,
    output logic signed [31:0]      o_speed_error
);
    import espl_pkg::*;

    localparam int unsigned CB = COUNTER_BITS;
    localparam logic signed [CB+1:0] Half = (CB+2)'((64'd1 << (CB - 1)) - 64'd1);
    localparam logic signed [CB+1:0] Modulus = (CB+2)'(1) <<< CB;
    // floor(y/25) = (y * ceil(2^36/25)) >> 36 for y below 2^31
    localparam logic [31:0] RecipTwentyFive = 32'd2748779070;
    // floor(x/3) = (x * ceil(2^16/3)) >> 16 for x below 2^15
    localparam logic [15:0] RecipThree = 16'd21846;

    // Input capture
    logic              r_en;
    logic [CB-1:0]     r_count;
    logic [31:0]       r_stamp;
    // Loop state
    logic [CB-1:0]     r_prev_count;
    logic [31:0]       r_prev_stamp;
    logic              r_running;
    logic signed [31:0] r_smooth, r_prev_err, r_err;
    logic signed [15:0] r_integ;
    // Working registers
    logic              r_neg;
    logic [CB-1:0]     r_mag;
    logic [31:0]       r_ticks;
    logic [25:0]       r_inc;
    logic signed [55:0] r_pterm, r_iterm, r_dterm;
    logic [9:0]        r_rpm;
    // Outputs
    logic              r_o_valid, r_o_ch;
    logic [9:0]        r_o_rpm;
    logic [29:0]       r_o_period;
    logic signed [31:0] r_o_speed, r_o_err;

    logic [63:0] r_dnum, r_dden;
    logic        r_div_go;
    logic        div_busy;
    logic [63:0] div_q;

    // Combinational helpers
    logic signed [CB+1:0] delta0, delta;
    logic [31:0]          ticks;
    logic                 init_clear;
    logic [31:0]          qmag;
    logic [8:0]           w;
    logic signed [31:0]   raw_now;
    logic signed [41:0]   fs2, fd2;
    logic signed [31:0]   filt_sat;
    logic signed [33:0]   err_full;
    logic signed [31:0]   err_sat;
    logic [31:0]          emag;
    logic [32:0]          emag_rnd;
    logic [63:0]          inc_prod;
    logic signed [27:0]   inc_s;
    logic signed [27:0]   integ_new;
    logic signed [15:0]   integ_cl;
    logic signed [33:0]   dd;
    logic signed [55:0]   psum;
    logic [14:0]          rpm20;
    logic [30:0]          rpm_prod;
    logic [12:0]          rpm400;

    espl_divider #(.W(64)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_go),
        .i_num  (r_dnum),
        .i_den  (r_dden),
        .o_busy (div_busy),
        .o_quot (div_q)
    );

    assign ticks      = r_stamp - r_prev_stamp;
    assign init_clear = !r_running;
    assign delta0     = $signed({2'b00, r_count}) - $signed({2'b00, r_prev_count});
    always_comb begin
        if (delta0 > Half) begin
            delta = delta0 - Modulus;
        end else if (delta0 < -Half) begin
            delta = delta0 + Modulus;
        end else begin
            delta = delta0;
        end
    end

    assign qmag    = (div_q > 64'd2147483648) ? 32'h8000_0000 : div_q[31:0];
    assign w       = (i_smoothing_weight > 9'd256) ? 9'd256 : i_smoothing_weight;
    assign raw_now = r_neg ? 32'(-33'(qmag)) : $signed(qmag);
    assign fs2     = $signed({1'b0, w}) * raw_now + $signed(10'(9'd256 - w)) * r_smooth;
    assign fd2     = fs2 >>> 8;
    assign filt_sat = (fd2 > 42'sd2147483647) ? 32'sh7FFF_FFFF
                    : (fd2 < -42'sd2147483648) ? 32'sh8000_0000 : fd2[31:0];

    assign err_full = $signed({16'd0, i_target_speed}) - 34'(r_smooth);
    always_comb begin
        if (err_full > 34'sd2147483647) begin
            err_sat = 32'sh7FFF_FFFF;
        end else if (err_full < -34'sd2147483648) begin
            err_sat = 32'sh8000_0000;
        end else begin
            err_sat = err_full[31:0];
        end
    end

    // Rounded |error| / 50 as a halving and a reciprocal multiply by 1/25
    assign emag      = r_err[31] ? 32'(-33'(r_err)) : r_err;
    assign emag_rnd  = 33'(emag) + 33'd25;
    assign inc_prod  = 64'(emag_rnd[32:1]) * 64'(RecipTwentyFive);
    assign inc_s     = 28'($signed({1'b0, r_inc}));
    assign integ_new = 28'(r_integ) + (r_err[31] ? -inc_s : inc_s);
    always_comb begin
        if (integ_new > 28'(IntegLimit)) begin
            integ_cl = 16'(IntegLimit);
        end else if (integ_new < -28'(IntegLimit)) begin
            integ_cl = -16'(IntegLimit);
        end else begin
            integ_cl = integ_new[15:0];
        end
    end
    assign dd = 34'(r_err) - 34'(r_prev_err);

    assign psum     = r_pterm + r_iterm + r_dterm;
    assign rpm20    = 15'(r_rpm) * 15'd20;
    assign rpm_prod = 31'(rpm20) * 31'(RecipThree);
    assign rpm400   = rpm_prod[28:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running    <= 1'b0;
            r_smooth     <= '0;
            r_integ      <= '0;
            r_prev_err   <= '0;
            r_prev_count <= '0;
            r_prev_stamp <= '0;
            r_div_go     <= 1'b0;
        end else begin
            r_div_go <= i_cmd.div_start;
            if (i_cmd.load) begin
                r_en    <= i_loop_enable;
                r_count <= CB'(i_encoder_count);
                r_stamp <= i_tick_stamp;
            end
            if (i_cmd.clear) begin
                r_running  <= 1'b0;
                r_integ    <= '0;
                r_prev_err <= '0;
                r_smooth   <= '0;
            end
            if (i_cmd.do_delta) begin
                if (init_clear) begin
                    r_integ    <= '0;
                    r_prev_err <= '0;
                    r_smooth   <= '0;
                    r_running  <= 1'b1;
                end
                r_neg   <= delta < 0;
                r_mag   <= CB'(delta < 0 ? -delta : delta);
                r_ticks <= ticks;
            end
            if (i_cmd.do_mul) begin
                // Round to nearest: (mag*num + den/2) / den
                r_dden   <= 64'(SpeedDen) * 64'(r_ticks);
                r_dnum   <= 64'(r_mag) * 64'(SpeedNum)
                          + ((64'(SpeedDen) * 64'(r_ticks)) >> 1);
                r_prev_count <= r_count;
                r_prev_stamp <= r_stamp;
            end
            if (i_cmd.do_filt) begin
                // A zero filter state loads the new sample directly
                if (r_smooth == 0) begin
                    r_smooth <= raw_now;
                end else begin
                    r_smooth <= filt_sat;
                end
            end
            if (i_cmd.do_err) begin
                r_err <= err_sat;
            end
            if (i_cmd.do_inc) begin
                r_inc <= inc_prod[61:36];
            end
            if (i_cmd.do_integ) begin
                r_integ    <= integ_cl;
                r_pterm    <= $signed({1'b0, i_gain_p}) * r_err;
                r_iterm    <= $signed({1'b0, i_gain_i}) * integ_cl;
                r_dterm    <= $signed({1'b0, i_gain_d}) * (56'(dd) * 56'sd50);
                r_prev_err <= r_err;
            end
            if (i_cmd.do_pid) begin
                if (psum <= 0) begin
                    r_rpm <= '0;
                end else if ((psum >>> 16) > 56'sd800) begin
                    r_rpm <= 10'(RpmMax);
                end else begin
                    r_rpm <= psum[25:16];
                end
            end
            if (i_cmd.do_freq) begin
                r_dnum <= 64'd1000000000;
                r_dden <= (rpm400 == 0) ? 64'd1 : 64'(rpm400);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_idle) begin
            r_o_valid  <= 1'b0;
            r_o_rpm    <= '0;
            r_o_period <= '0;
            r_o_ch     <= 1'b0;
            r_o_speed  <= '0;
            r_o_err    <= '0;
        end else if (i_cmd.out_load) begin
            r_o_valid  <= 1'b1;
            r_o_rpm    <= r_rpm;
            r_o_period <= div_q[29:0];
            r_o_ch     <= i_reverse_direction;
            r_o_speed  <= r_smooth;
            r_o_err    <= r_err;
        end
    end

    assign o_sts.enable     = r_en;
    assign o_sts.zero_ticks = (ticks == 32'd0);
    assign o_sts.div_busy   = div_busy | r_div_go;

    assign o_drive_valid     = r_o_valid;
    assign o_drive_rpm       = r_o_rpm;
    assign o_pulse_period_ns = r_o_period;
    assign o_pulse_high_ns   = r_o_period[29:1];
    assign o_drive_channel   = r_o_ch;
    assign o_speed_now       = r_o_speed;
    assign o_speed_error     = r_o_err;
endmodule

// ===== src/encoder_speed_pid_loop.sv =====
// Top level: encoder speed PID loop with step-pulse period output.
//
//  channel | signals                                   | direction
//  input   | i_in_valid / o_in_ready, item fields      | in
//  result  | o_out_valid / i_out_ready, result fields  | out
//  config  | i_cfg_valid / o_cfg_ready, index, data    | in
//
// An enabled tick makes two passes through the 64-step shared divider between acceptance
// and the next ready: first the speed quotient, then the pulse period.
// Zero elapsed time skips the speed quotient. Disabled ticks clear the loop and go to the output step.
// Reset is synchronous and restores register defaults and clears the loop.
// A result held in the output register stalls only the final step.
`timescale 1ns / 1ps
module encoder_speed_pid_loop #(
    parameter int unsigned COUNTER_BITS = espl_pkg::CounterBitsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_loop_enable,
    input  logic [15:0]        i_encoder_count,
    input  logic [31:0]        i_tick_stamp,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_drive_valid,
    output logic [9:0]         o_drive_rpm,
    output logic [29:0]        o_pulse_period_ns,
    output logic [28:0]        o_pulse_high_ns,
    output logic               o_drive_channel,
    output logic signed [31:0] o_speed_now,
    output logic signed [31:0] o_speed_error,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import espl_pkg::*;

    logic [17:0] r_target;
    logic [15:0] r_gp, r_gi, r_gd;
    logic [8:0]  r_w;
    logic        r_rev;
    t_cmd        cmd;
    t_sts        sts;
    t_state      state;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= 18'd51200;
            r_gp     <= 16'd256;
            r_gi     <= 16'd13;
            r_gd     <= 16'd0;
            r_w      <= 9'd128;
            r_rev    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TARGET:  r_target <= i_cfg_data[17:0];
                CFG_GAIN_P:  r_gp     <= i_cfg_data[15:0];
                CFG_GAIN_I:  r_gi     <= i_cfg_data[15:0];
                CFG_GAIN_D:  r_gd     <= i_cfg_data[15:0];
                CFG_WEIGHT:  r_w      <= i_cfg_data[8:0];
                CFG_REVERSE: r_rev    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    espl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_state    (state)
    );

    espl_datapath #(.COUNTER_BITS(COUNTER_BITS)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_loop_enable      (i_loop_enable),
        .i_encoder_count    (i_encoder_count),
        .i_tick_stamp       (i_tick_stamp),
        .i_target_speed     (r_target),
        .i_gain_p           (r_gp),
        .i_gain_i           (r_gi),
        .i_gain_d           (r_gd),
        .i_smoothing_weight (r_w),
        .i_reverse_direction(r_rev),
        .o_drive_valid      (o_drive_valid),
        .o_drive_rpm        (o_drive_rpm),
        .o_pulse_period_ns  (o_pulse_period_ns),
        .o_pulse_high_ns    (o_pulse_high_ns),
        .o_drive_channel    (o_drive_channel),
        .o_speed_now        (o_speed_now),
        .o_speed_error      (o_speed_error)
    );

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (state == ST_IDLE))
        else $error("input ready outside idle");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while busy");
    a_rpm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive_rpm <= 10'd800))
        else $error("rpm out of range");
endmodule

// ===== sim/encoder_speed_pid_loop_tb.sv =====
// Self-checking testbench for the encoder speed PID loop with randomized handshakes.
`timescale 1ns / 1ps
module encoder_speed_pid_loop_tb;
    import espl_pkg::*;

    typedef struct {
        bit        drive_valid;
        bit [9:0]  rpm;
        bit [29:0] period;
        bit [28:0] high;
        bit        channel;
        int        speed;
        int        err;
    } drive_t;

    class drive_scoreboard;
        bit [17:0] target;
        bit [15:0] kp, ki, kd;
        bit [8:0]  weight;
        bit        reverse;
        int        smoothed, integ, prev_err;
        bit [15:0] prev_count;
        bit [31:0] prev_stamp;
        bit        running;
        drive_t    pending[$];
        int        errors, checked, enabled_ticks;

        function void reset_state();
            target = 51200; kp = 256; ki = 13; kd = 0; weight = 128; reverse = 0;
            smoothed = 0; integ = 0; prev_err = 0; prev_count = 0; prev_stamp = 0;
            running = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, bit [31:0] data);
            case (idx)
                CFG_TARGET:  target = data[17:0];
                CFG_GAIN_P:  kp = data[15:0];
                CFG_GAIN_I:  ki = data[15:0];
                CFG_GAIN_D:  kd = data[15:0];
                CFG_WEIGHT:  weight = data[8:0];
                CFG_REVERSE: reverse = data[0];
                default: ;
            endcase
        endfunction

        function int sat(longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return int'(v);
        endfunction

        function void note_tick(bit en, bit [15:0] count, bit [31:0] stamp);
            drive_t r;
            bit [31:0] ticks;
            longint delta, raw, w, acc, inc, sum, deriv;
            longint unsigned mag, den;
            int e;
            r = '{default: 0};
            if (!en) begin
                running = 0; integ = 0; prev_err = 0; smoothed = 0;
                pending.push_back(r);
                return;
            end
            enabled_ticks++;
            if (!running) begin
                integ = 0; prev_err = 0; smoothed = 0; running = 1;
            end
            ticks = stamp - prev_stamp;
            if (ticks != 0) begin
                delta = longint'(count) - longint'(prev_count);
                if (delta > 32767) delta -= 65536;
                else if (delta < -32767) delta += 65536;
                mag = delta < 0 ? -delta : delta;
                den = 64'd2500 * ticks;
                mag = (mag * 64'd60318592 + den / 2) / den;
                if (mag > 64'd2147483648) mag = 64'd2147483648;
                raw = sat(delta < 0 ? -longint'(mag) : longint'(mag));
                if (smoothed == 0) smoothed = int'(raw);
                else begin
                    w = weight > 256 ? 256 : weight;
                    acc = w * raw + (256 - w) * longint'(smoothed);
                    acc = acc >= 0 ? acc >>> 8 : -((-acc + 255) >>> 8);
                    smoothed = sat(acc);
                end
                prev_count = count;
                prev_stamp = stamp;
            end
            e = sat(longint'(target) - longint'(smoothed));
            mag = e < 0 ? -longint'(e) : e;
            inc = (mag + 25) / 50;
            if (e < 0) inc = -inc;
            inc += integ;
            if (inc > IntegLimit) inc = IntegLimit;
            if (inc < -IntegLimit) inc = -IntegLimit;
            integ = int'(inc);
            deriv = (longint'(e) - longint'(prev_err)) * 50;
            sum = longint'(kp) * e + longint'(ki) * inc + longint'(kd) * deriv;
            r.rpm = sum <= 0 ? 0 : ((sum >>> 16) > RpmMax ? RpmMax : sum >>> 16);
            prev_err = e;
            begin
                int unsigned freq;
                freq = (r.rpm * 400) / 60;
                if (freq < 1) freq = 1;
                r.period = 1000000000 / freq;
                r.high = (1000000000 / freq) / 2;
            end
            r.drive_valid = 1;
            r.channel = reverse;
            r.speed = smoothed;
            r.err = e;
            pending.push_back(r);
        endfunction

        function void check_drive(drive_t got);
            drive_t x;
            if (pending.size() == 0) begin
                $error("result with nothing pending");
                errors++;
                return;
            end
            x = pending.pop_front();
            checked++;
            if (got.drive_valid != x.drive_valid) begin
                $error("drive_valid exp %0d got %0d", x.drive_valid, got.drive_valid); errors++;
            end
            if (got.rpm != x.rpm) begin
                $error("drive_rpm exp %0d got %0d", x.rpm, got.rpm); errors++;
            end
            if (got.period != x.period) begin
                $error("pulse_period_ns exp %0d got %0d", x.period, got.period); errors++;
            end
            if (got.high != x.high) begin
                $error("pulse_high_ns exp %0d got %0d", x.high, got.high); errors++;
            end
            if (got.channel != x.channel) begin
                $error("drive_channel exp %0d got %0d", x.channel, got.channel); errors++;
            end
            if (got.speed != x.speed) begin
                $error("speed_now exp %0d got %0d", x.speed, got.speed); errors++;
            end
            if (got.err != x.err) begin
                $error("speed_error exp %0d got %0d", x.err, got.err); errors++;
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_in_valid = 0, i_loop_enable = 0, i_out_ready = 0, i_cfg_valid = 0;
    logic [15:0] i_encoder_count = 0;
    logic [31:0] i_tick_stamp = 0, i_cfg_data = 0;
    logic [2:0] i_cfg_index = 0;
    logic o_in_ready, o_out_valid, o_cfg_ready, o_drive_valid, o_drive_channel;
    logic [9:0] o_drive_rpm;
    logic [29:0] o_pulse_period_ns;
    logic [28:0] o_pulse_high_ns;
    logic signed [31:0] o_speed_now, o_speed_error;

    drive_scoreboard sb = new();
    int cycles = 0;
    bit quiet = 0;
    bit [15:0] enc_pos = 0;
    bit [31:0] stamp_now = 0;

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    encoder_speed_pid_loop i_dut (.*);

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 2000000) begin
            $display("encoder_speed_pid_loop_tb failed");
            $finish;
        end
    end

    // sample results at the rising edge, then pick the next ready level
    always @(posedge i_clk) begin
        drive_t g;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            g.drive_valid = o_drive_valid; g.rpm = o_drive_rpm;
            g.period = o_pulse_period_ns; g.high = o_pulse_high_ns;
            g.channel = o_drive_channel; g.speed = o_speed_now; g.err = o_speed_error;
            sb.check_drive(g);
        end
    end
    always @(negedge i_clk) i_out_ready <= quiet || ($urandom_range(99) >= 28);

    task automatic send_tick(bit en, bit [15:0] count, bit [31:0] stamp);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 28) @(negedge i_clk);
        i_in_valid <= 1; i_loop_enable <= en;
        i_encoder_count <= count; i_tick_stamp <= stamp;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_tick(en, count, stamp);
        @(negedge i_clk);
        i_in_valid <= 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, bit [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // advance a plausible motion: small count steps, mostly 20 ticks apart
    task automatic motion_tick();
        int r;
        r = $urandom_range(99);
        if (r < 5) stamp_now = stamp_now;
        else if (r < 10) stamp_now += $urandom_range(1, 5);
        else if (r < 13) stamp_now = $urandom;
        else stamp_now += 20;
        if (r < 16) enc_pos = $urandom;
        else enc_pos += $urandom_range(0, 600) - 200;
        send_tick($urandom_range(99) >= 6, enc_pos, stamp_now);
    endtask

    task automatic random_config(bit extreme);
        write_reg(CFG_TARGET, extreme ? ($urandom_range(1) ? 0 : 32'h3ffff) : $urandom_range(256000));
        write_reg(CFG_GAIN_P, extreme ? ($urandom_range(1) ? 0 : 16'hffff) : $urandom);
        write_reg(CFG_GAIN_I, extreme ? ($urandom_range(1) ? 0 : 16'hffff) : $urandom_range(600));
        write_reg(CFG_GAIN_D, extreme ? ($urandom_range(1) ? 0 : 16'hffff) : $urandom_range(40));
        write_reg(CFG_WEIGHT, extreme ? ($urandom_range(1) ? 0 : 9'h1ff) : $urandom_range(256));
        write_reg(CFG_REVERSE, $urandom_range(1));
    endtask

    initial begin
        sb.reset_state();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: disable, first tick, zero elapsed, wraps, extremes
        send_tick(0, 16'hffff, 32'hffffffff);
        send_tick(1, 100, 20);
        send_tick(1, 300, 20);
        send_tick(1, 500, 40);
        send_tick(1, 16'hfff0, 60);
        send_tick(1, 16'h0010, 80);
        send_tick(1, 16'h7fff, 81);
        send_tick(1, 16'h8000, 82);
        send_tick(1, 0, 32'hffffffff);
        send_tick(0, 0, 0);
        send_tick(1, 16'hffff, 32'h00000001);
        drain();
        write_reg(CFG_TARGET, 32'hffffffff);
        write_reg(CFG_GAIN_P, 16'hffff);
        write_reg(CFG_GAIN_I, 16'hffff);
        write_reg(CFG_GAIN_D, 16'hffff);
        write_reg(CFG_WEIGHT, 9'h1ff);
        write_reg(CFG_REVERSE, 1);
        send_tick(1, 1000, 100);
        send_tick(1, 16'h5555, 101);
        send_tick(1, 16'haaaa, 102);
        send_tick(1, 16'haaaa, 132);
        drain();
        write_reg(CFG_WEIGHT, 0);
        write_reg(CFG_TARGET, 0);
        write_reg(CFG_GAIN_D, 0);
        send_tick(1, 0, 200);
        send_tick(1, 16'h8001, 201);
        send_tick(1, 16'h8001, 202);
        drain();

        // random phases, one quiet stretch, one pause until empty
        for (int ph = 0; ph < 16; ph++) begin
            random_config(ph % 5 == 0);
            quiet = (ph == 3);
            for (int k = 0; k < 100; k++) begin
                motion_tick();
                if (ph == 7 && k == 50) while (sb.pending.size() != 0) @(posedge i_clk);
            end
            quiet = 0;
            drain();
        end

        $display("%0d results checked, %0d enabled ticks over 16 register settings",
                 sb.checked, sb.enabled_ticks);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("encoder_speed_pid_loop_tb passed");
        end else begin
            $display("encoder_speed_pid_loop_tb failed");
        end
        $finish;
    end
endmodule
